[rtl/core/rtb_pkg.sv]
// Shared types and constants for the reload timer bank.
`timescale 1ns / 1ps
`default_nettype none

package rtb_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam logic [31:0] RESET_TICKS = 32'd10;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_SET_COUNT   = 3'd1,
    CMD_SET_RELOAD  = 3'd2,
    CMD_READ_TIMER  = 3'd3,
    CMD_READ_UPTIME = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

[rtl/core/rtb_timer_mem.sv]
// Counter and reload memories with per-entry written flags and reset defaults.
`timescale 1ns / 1ps
`default_nettype none

module rtb_timer_mem #(
  parameter int NUM_TIMERS = rtb_pkg::NUM_TIMERS_DEF,
  parameter int IDX_W      = 3
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  input  wire logic             wr_cnt,
  input  wire logic             wr_rld,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [31:0]      wr_data,
  output logic      [31:0]      cnt,
  output logic      [31:0]      rld
);

  logic [31:0] cnt_mem [NUM_TIMERS];
  logic [31:0] rld_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] cnt_ok;
  logic [NUM_TIMERS-1:0] rld_ok;

  logic [31:0]      cnt_raw;
  logic [31:0]      rld_raw;
  logic             cnt_hit;
  logic             rld_hit;
  logic [IDX_W-1:0] addr_q;

  always_ff @(posedge clk) begin
    if (wr_cnt) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    if (wr_rld) begin
      rld_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      cnt_raw <= cnt_mem[rd_addr];
      rld_raw <= rld_mem[rd_addr];
      cnt_hit <= cnt_ok[rd_addr];
      rld_hit <= rld_ok[rd_addr];
      addr_q  <= rd_addr;
    end
  end

  // unwritten entries read as their reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_ok <= '0;
      rld_ok <= '0;
    end else begin
      if (wr_cnt) begin
        cnt_ok[wr_addr] <= 1'b1;
      end
      if (wr_rld) begin
        rld_ok[wr_addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    cnt = cnt_hit ? cnt_raw : ((addr_q == '0) ? rtb_pkg::RESET_TICKS : 32'd0);
    rld = rld_hit ? rld_raw : ((addr_q == '0) ? rtb_pkg::RESET_TICKS : 32'd0);
  end

endmodule

`default_nettype wire

[rtl/core/reload_timer_bank_core.sv]
// Reload timer bank: top level with command sequencer, uptime and result register.
//
// A bank of NUM_TIMERS countdown timers held in two single-port-read memories
// (counter and reload), plus a 64-bit uptime counter. A tick increments uptime
// and then sweeps the timers in ascending order, one memory read and one
// write-back per cycle unless the result side holds the sweep off; each
// expiry gives one result, the final one marked last, and a tick without
// expiry gives none. Set counter, set reload, read timer and read uptime
// give one result each. Requests are taken one at a time; a new request
// is taken while the previous result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module reload_timer_bank_core #(
  parameter int NUM_TIMERS = rtb_pkg::NUM_TIMERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire logic [2:0]  command,
  input  wire logic [7:0]  index,
  input  wire logic [31:0] value,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic             expired,
  output logic [2:0]       expired_index,
  output logic [31:0]      counter_value,
  output logic [31:0]      reload_value,
  output logic             index_error,
  output logic [31:0]      uptime_high,
  output logic [31:0]      uptime_low,
  output logic             last
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_TMR = IDX_W'(NUM_TIMERS - 1);

  rtb_pkg::state_t state, state_next;

  logic [2:0]       cmd_q;
  logic [7:0]       idx_q;
  logic [31:0]      val_q;
  logic             idx_ok_q;
  logic [63:0]      uptime;
  logic [IDX_W-1:0] tmr;
  logic             pend_valid;
  logic [2:0]       pend_index;

  logic             in_ok;
  logic             slot_free;
  logic             accept;
  logic             tick_acc;
  logic             tmr_inc;
  logic             pend_set;
  logic             pend_clr;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_cnt;
  logic             wr_rld;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;
  logic [31:0]      mem_cnt;
  logic [31:0]      mem_rld;

  logic             nz;
  logic             expire;
  logic [31:0]      new_cnt;

  logic             load;
  logic             ld_exp;
  logic [2:0]       ld_eidx;
  logic [31:0]      ld_cnt;
  logic [31:0]      ld_rld;
  logic             ld_err;
  logic             ld_up;
  logic             ld_last;

  rtb_timer_mem #(
    .NUM_TIMERS(NUM_TIMERS),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .wr_cnt (wr_cnt),
    .wr_rld (wr_rld),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .cnt    (mem_cnt),
    .rld    (mem_rld)
  );

  assign in_ok     = {1'b0, index} < 9'(NUM_TIMERS);
  assign slot_free = !res_valid || res_ready;
  assign accept    = cmd_valid && cmd_ready;

  assign nz      = mem_cnt != 32'd0;
  assign expire  = mem_cnt == 32'd1;
  assign new_cnt = expire ? mem_rld : mem_cnt - 32'd1;

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    tick_acc   = 1'b0;
    tmr_inc    = 1'b0;
    pend_set   = 1'b0;
    pend_clr   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = tmr;
    wr_cnt     = 1'b0;
    wr_rld     = 1'b0;
    wr_addr    = idx_q[IDX_W-1:0];
    wr_data    = val_q;
    load       = 1'b0;
    ld_exp     = 1'b0;
    ld_eidx    = 3'd0;
    ld_cnt     = 32'd0;
    ld_rld     = 32'd0;
    ld_err     = 1'b0;
    ld_up      = 1'b0;
    ld_last    = 1'b0;
    case (state)
      rtb_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        rd_addr   = index[IDX_W-1:0];
        if (cmd_valid) begin
          case (command)
            rtb_pkg::CMD_TICK: begin
              tick_acc   = 1'b1;
              rd_en      = 1'b1;
              rd_addr    = '0;
              state_next = rtb_pkg::ST_TICK;
            end
            rtb_pkg::CMD_READ_TIMER: begin
              rd_en      = in_ok;
              state_next = rtb_pkg::ST_EXEC;
            end
            rtb_pkg::CMD_SET_COUNT,
            rtb_pkg::CMD_SET_RELOAD,
            rtb_pkg::CMD_READ_UPTIME: begin
              state_next = rtb_pkg::ST_EXEC;
            end
            default: begin
              state_next = rtb_pkg::ST_IDLE;
            end
          endcase
        end
      end
      rtb_pkg::ST_EXEC: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_last    = 1'b1;
          state_next = rtb_pkg::ST_IDLE;
          if (cmd_q == rtb_pkg::CMD_READ_UPTIME) begin
            ld_up = 1'b1;
          end else if (!idx_ok_q) begin
            ld_err = 1'b1;
          end else begin
            case (cmd_q)
              rtb_pkg::CMD_SET_COUNT:  wr_cnt = 1'b1;
              rtb_pkg::CMD_SET_RELOAD: wr_rld = 1'b1;
              rtb_pkg::CMD_READ_TIMER: begin
                ld_cnt = mem_cnt;
                ld_rld = mem_rld;
              end
              default: ld_err = 1'b0;
            endcase
          end
        end
      end
      rtb_pkg::ST_TICK: begin
        // hold while a new expiry would overrun the pending slot
        if (!(expire && pend_valid && !slot_free)) begin
          wr_cnt  = nz;
          wr_addr = tmr;
          wr_data = new_cnt;
          if (expire) begin
            pend_set = 1'b1;
            if (pend_valid) begin
              load    = 1'b1;
              ld_exp  = 1'b1;
              ld_eidx = pend_index;
            end
          end
          if (tmr == LAST_TMR) begin
            state_next = rtb_pkg::ST_FLUSH;
          end else begin
            tmr_inc = 1'b1;
            rd_en   = 1'b1;
            rd_addr = tmr + IDX_W'(1);
          end
        end
      end
      rtb_pkg::ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = rtb_pkg::ST_IDLE;
        end else if (slot_free) begin
          load       = 1'b1;
          ld_exp     = 1'b1;
          ld_eidx    = pend_index;
          ld_last    = 1'b1;
          pend_clr   = 1'b1;
          state_next = rtb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rtb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= command;
      idx_q    <= index;
      val_q    <= value;
      idx_ok_q <= in_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uptime     <= 64'd0;
      tmr        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (tick_acc) begin
        uptime <= uptime + 64'd1;
        tmr    <= '0;
      end else if (tmr_inc) begin
        tmr <= tmr + IDX_W'(1);
      end
      if (pend_set) begin
        pend_valid <= 1'b1;
      end else if (pend_clr) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_set) begin
      pend_index <= 3'(tmr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      expired       <= ld_exp;
      expired_index <= ld_eidx;
      counter_value <= ld_cnt;
      reload_value  <= ld_rld;
      index_error   <= ld_err;
      uptime_high   <= ld_up ? uptime[63:32] : 32'd0;
      uptime_low    <= ld_up ? uptime[31:0] : 32'd0;
      last          <= ld_last;
    end
  end

`ifndef SYNTHESIS
  a_pend_in_tick: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == rtb_pkg::ST_TICK || state == rtb_pkg::ST_FLUSH))
    else $error("pending expiry outside a tick");

  a_no_load_idle: assert property (@(posedge clk) disable iff (rst)
    load |-> (state != rtb_pkg::ST_IDLE))
    else $error("result loaded while idle");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && (wr_cnt || wr_rld)) |-> (rd_addr != wr_addr))
    else $error("read and write of the same timer entry in one cycle");
`endif

endmodule

`default_nettype wire
